// ===== rtl/core/llj_pkg.sv =====
package llj_pkg;

  // Field widths
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned LOAD_W = 32;
  localparam int unsigned WAIT_W = 48;
  localparam int unsigned CIDX_W = 4;
  localparam int unsigned CFG_W  = 5;

  // Default number of counter cells
  localparam int unsigned MAX_COUNTERS_DEF = 16;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic [LOAD_W-1:0] load;
  } tok_t;

  // Load write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic              clr;
    logic [LOAD_W-1:0] load;
  } wr_t;

endpackage

// ===== rtl/core/llj_cell.sv =====
module llj_cell #(
  parameter int unsigned MAX_COUNTERS = llj_pkg::MAX_COUNTERS_DEF,
  parameter int unsigned CELL_IDX     = 0,
  localparam int unsigned IDX_W = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               active,
  input  llj_pkg::tok_t      tok_in,
  input  logic [IDX_W-1:0]   idx_in,
  input  llj_pkg::wr_t       wr,
  input  logic [IDX_W-1:0]   wr_idx,
  output llj_pkg::tok_t      tok_out,
  output logic [IDX_W-1:0]   idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [llj_pkg::LOAD_W-1:0] load_r;
  llj_pkg::tok_t              tok_r;
  llj_pkg::tok_t              tok_nxt;
  logic [IDX_W-1:0]           idx_r;
  logic [IDX_W-1:0]           idx_nxt;
  logic                       take;

  // Replace the best so far when this counter is strictly lighter
  assign take = active && tok_in.vld && (load_r < tok_in.load);

  always_comb begin
    tok_nxt = tok_in;
    idx_nxt = idx_in;
    if (take) begin
      tok_nxt.load = load_r;
      idx_nxt      = MY_IDX;
    end
  end

  // Advance the token one cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r.vld <= tok_nxt.vld;
    end
    if (adv) begin
      tok_r.load <= tok_nxt.load;
      idx_r      <= idx_nxt;
    end
  end

  // Hold this counter's load; clear at end of batch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
    end else if (wr.clr) begin
      load_r <= '0;
    end else if (wr.en && (wr_idx == MY_IDX)) begin
      load_r <= wr.load;
    end
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

// ===== rtl/core/least_loaded_job_dispatch.sv =====
// Greedy least-loaded dispatcher. Each job word carries a duration and is sent
// to the active counter with the smallest load (lowest index on a tie); the
// result word gives that counter, the job's start time, the running makespan
// and the running sum of start times, all saturating. A search token walks
// the row of counter cells one cell per clock while the row is not stalled,
// and the clock that takes it out of the last cell also writes the new load
// back and forms the result. Busy clears at write-back, so the next job can
// be accepted in the cycle after it; no new job is taken before the previous
// one is written back, while the previous result word may still be waiting.
// A result that cannot be handed over stalls the token at the end of the row.
// cfg_wr_data sets the number of active counters (0 acts as 1, above
// MAX_COUNTERS acts as MAX_COUNTERS); the user must write it only while no
// job is in flight, and the block itself does not enforce this. A job marked
// last_job clears every load and total once its result is formed.
module least_loaded_job_dispatch #(
  parameter int unsigned MAX_COUNTERS = llj_pkg::MAX_COUNTERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [llj_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [llj_pkg::DUR_W-1:0]     in_duration,
  input  logic                          in_last_job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [llj_pkg::CIDX_W-1:0]    out_counter_index,
  output logic [llj_pkg::LOAD_W-1:0]    out_start_time,
  output logic [llj_pkg::LOAD_W-1:0]    out_makespan,
  output logic [llj_pkg::WAIT_W-1:0]    out_total_wait,
  output logic                          out_batch_done
);

  localparam int unsigned IDX_W = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
  localparam int unsigned LW    = llj_pkg::LOAD_W;
  localparam int unsigned WW    = llj_pkg::WAIT_W;

  logic [MAX_COUNTERS-1:0]     active_r;
  logic                        busy_r;
  logic [llj_pkg::DUR_W-1:0]   dur_r;
  logic                        last_r;
  logic [LW-1:0]               mk_r;
  logic [WW-1:0]               wait_r;

  llj_pkg::tok_t               tok_w [MAX_COUNTERS+1];
  logic [IDX_W-1:0]            idx_w [MAX_COUNTERS+1];

  logic                        accept;
  logic                        adv;
  logic                        commit;
  llj_pkg::wr_t                wr;
  logic [LW:0]                 load_sum;
  logic [LW-1:0]               load_new;
  logic [WW:0]                 wait_sum;
  logic [WW-1:0]               wait_new;
  logic [LW-1:0]               mk_new;
  logic [IDX_W+llj_pkg::CIDX_W-1:0] idx_ext;

  logic                        out_valid_r;
  logic [llj_pkg::CIDX_W-1:0]  out_idx_r;
  logic [LW-1:0]               out_start_r;
  logic [LW-1:0]               out_mk_r;
  logic [WW-1:0]               out_wait_r;
  logic                        out_done_r;

  // Handshake and token flow
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign adv      = !(tok_w[MAX_COUNTERS].vld && out_valid_r && !out_ready);
  assign commit   = tok_w[MAX_COUNTERS].vld && adv;

  // Active counter mask, refreshed on each configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= MAX_COUNTERS'(1);
    end else if (cfg_wr_en) begin
      for (int i = 0; i < MAX_COUNTERS; i++) begin
        active_r[i] <= (i == 0) || (32'(i) < 32'(cfg_wr_data));
      end
    end
  end

  // Capture the job word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (commit) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dur_r  <= in_duration;
      last_r <= in_last_job;
    end
  end

  // Seed token: heaviest possible load at counter zero
  assign tok_w[0].vld  = accept;
  assign tok_w[0].load = '1;
  assign idx_w[0]      = '0;

  // Row of counter cells
  for (genvar g = 0; g < MAX_COUNTERS; g++) begin : g_cell
    llj_cell #(
      .MAX_COUNTERS (MAX_COUNTERS),
      .CELL_IDX     (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .active  (active_r[g]),
      .tok_in  (tok_w[g]),
      .idx_in  (idx_w[g]),
      .wr      (wr),
      .wr_idx  (idx_w[MAX_COUNTERS]),
      .tok_out (tok_w[g+1]),
      .idx_out (idx_w[g+1])
    );
  end

  // Saturating load and wait updates
  always_comb begin
    load_sum = {1'b0, tok_w[MAX_COUNTERS].load} + (LW+1)'(dur_r);
    load_new = load_sum[LW] ? '1 : load_sum[LW-1:0];
    wait_sum = {1'b0, wait_r} + (WW+1)'(tok_w[MAX_COUNTERS].load);
    wait_new = wait_sum[WW] ? '1 : wait_sum[WW-1:0];
    mk_new   = (load_new > mk_r) ? load_new : mk_r;
    idx_ext  = (IDX_W+llj_pkg::CIDX_W)'(idx_w[MAX_COUNTERS]);
  end

  // Write back the chosen load, or clear the batch
  assign wr.en   = commit;
  assign wr.clr  = commit && last_r;
  assign wr.load = load_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mk_r   <= '0;
      wait_r <= '0;
    end else if (commit) begin
      if (last_r) begin
        mk_r   <= '0;
        wait_r <= '0;
      end else begin
        mk_r   <= mk_new;
        wait_r <= wait_new;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_idx_r   <= idx_ext[llj_pkg::CIDX_W-1:0];
      out_start_r <= tok_w[MAX_COUNTERS].load;
      out_mk_r    <= mk_new;
      out_wait_r  <= wait_new;
      out_done_r  <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_counter_index = out_idx_r;
  assign out_start_time    = out_start_r;
  assign out_makespan      = out_mk_r;
  assign out_total_wait    = out_wait_r;
  assign out_batch_done    = out_done_r;

  // At most one search token in the row
  logic [MAX_COUNTERS:0] tok_vld_vec;
  always_comb begin
    for (int i = 0; i <= MAX_COUNTERS; i++) begin
      tok_vld_vec[i] = tok_w[i].vld;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld_vec))
    else $error("more than one search token in flight");

  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && last_r) |=> (mk_r == '0 && wait_r == '0))
    else $error("totals not cleared after last job");

  a_start_le_mk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_start_r <= out_mk_r))
    else $error("start time above makespan");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !commit)
    else $error("result word overwritten while waiting");

endmodule

// ===== dv/least_loaded_job_dispatch_test.sv =====
module least_loaded_job_dispatch_test;

  localparam int unsigned MAX_CNT     = llj_pkg::MAX_COUNTERS_DEF;
  localparam int unsigned RANDOM_JOBS = 1400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [llj_pkg::CIDX_W-1:0] counter_index;
    logic [llj_pkg::LOAD_W-1:0] start_time;
    logic [llj_pkg::LOAD_W-1:0] makespan;
    logic [llj_pkg::WAIT_W-1:0] total_wait;
    logic                       batch_done;
  } dispatch_t;

  typedef struct packed {
    logic                      wr_cfg;
    logic [llj_pkg::CFG_W-1:0] cfg;
    logic [llj_pkg::DUR_W-1:0] dur;
    logic                      last;
    logic                      typed;
    dispatch_t                 want;
  } job_row_t;

  localparam dispatch_t NO_WANT = '0;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [llj_pkg::CFG_W-1:0]  cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [llj_pkg::DUR_W-1:0]  in_duration;
  logic                       in_last_job;
  logic                       out_valid;
  logic                       out_ready;
  logic [llj_pkg::CIDX_W-1:0] out_counter_index;
  logic [llj_pkg::LOAD_W-1:0] out_start_time;
  logic [llj_pkg::LOAD_W-1:0] out_makespan;
  logic [llj_pkg::WAIT_W-1:0] out_total_wait;
  logic                       out_batch_done;

  // Mirror of the dispatcher state
  logic [llj_pkg::LOAD_W-1:0] load_mirror [MAX_CNT];
  logic [llj_pkg::LOAD_W-1:0] makespan_mirror;
  logic [llj_pkg::WAIT_W-1:0] wait_mirror;
  logic [llj_pkg::CFG_W-1:0]  active_mirror;

  dispatch_t   pending_dispatches [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          burst_mode  = 1'b0;

  // Directed jobs: expectations typed in where they are obvious, else predicted
  job_row_t job_table [20] = '{
    // after reset: one counter
    '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{4'd0, 32'd0,     32'd0,      48'd0,     1'b0}},
    '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{4'd0, 32'd0,     32'hFFFF,   48'd0,     1'b0}},
    '{1'b0, 5'd0,  16'h0001, 1'b1, 1'b1, '{4'd0, 32'hFFFF,  32'h10000,  48'hFFFF,  1'b1}},
    // zero active counters behaves as one
    '{1'b1, 5'd0,  16'h0005, 1'b0, 1'b1, '{4'd0, 32'd0,     32'd5,      48'd0,     1'b0}},
    '{1'b0, 5'd0,  16'h0003, 1'b1, 1'b1, '{4'd0, 32'd5,     32'd8,      48'd5,     1'b1}},
    // above the maximum behaves as sixteen; ties go to the lowest index
    '{1'b1, 5'd31, 16'h0064, 1'b0, 1'b1, '{4'd0, 32'd0,     32'd100,    48'd0,     1'b0}},
    '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{4'd1, 32'd0,     32'd100,    48'd0,     1'b0}},
    '{1'b0, 5'd0,  16'h0032, 1'b0, 1'b1, '{4'd1, 32'd0,     32'd100,    48'd0,     1'b0}},
    '{1'b0, 5'd0,  16'h0014, 1'b0, 1'b1, '{4'd2, 32'd0,     32'd100,    48'd0,     1'b0}},
    '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0,  16'h8000, 1'b0, 1'b0, NO_WANT},
    // narrow mid-batch: dropped counters keep their loads in the makespan
    '{1'b1, 5'd2,  16'h0010, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0,  16'h0040, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0,  16'h0001, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 5'd17, 16'hFFFF, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0,  16'h7FFF, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0,  16'hAAAA, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0,  16'h5555, 1'b1, 1'b0, NO_WANT},
    '{1'b1, 5'd16, 16'h1234, 1'b0, 1'b0, NO_WANT},
    '{1'b0, 5'd0,  16'h0000, 1'b1, 1'b0, NO_WANT}
  };

  least_loaded_job_dispatch #(.MAX_COUNTERS(MAX_CNT)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_duration       (in_duration),
    .in_last_job       (in_last_job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_counter_index (out_counter_index),
    .out_start_time    (out_start_time),
    .out_makespan      (out_makespan),
    .out_total_wait    (out_total_wait),
    .out_batch_done    (out_batch_done)
  );

  always #1 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void clear_batch_mirror();
    int unsigned i;
    for (i = 0; i < MAX_CNT; i++)
      load_mirror[i] = '0;
    makespan_mirror = '0;
    wait_mirror     = '0;
  endfunction

  // Place one job on the least loaded active counter and return its result word
  function automatic dispatch_t dispatch_job(input logic [llj_pkg::DUR_W-1:0] dur,
                                             input logic last);
    dispatch_t                  r;
    int unsigned                span;
    int unsigned                pick;
    int unsigned                i;
    logic [llj_pkg::LOAD_W:0]   grown;
    logic [llj_pkg::WAIT_W:0]   summed;
    span = active_mirror;
    if (span == 0)
      span = 1;
    if (span > MAX_CNT)
      span = MAX_CNT;
    pick = 0;
    for (i = 1; i < span; i++)
      if (load_mirror[i] < load_mirror[pick])
        pick = i;
    r.counter_index = pick[llj_pkg::CIDX_W-1:0];
    r.start_time    = load_mirror[pick];
    // saturate the load, then the wait sum
    grown = {1'b0, load_mirror[pick]} + (llj_pkg::LOAD_W+1)'(dur);
    load_mirror[pick] = grown[llj_pkg::LOAD_W] ? '1 : grown[llj_pkg::LOAD_W-1:0];
    if (load_mirror[pick] > makespan_mirror)
      makespan_mirror = load_mirror[pick];
    summed = {1'b0, wait_mirror} + (llj_pkg::WAIT_W+1)'(r.start_time);
    wait_mirror  = summed[llj_pkg::WAIT_W] ? '1 : summed[llj_pkg::WAIT_W-1:0];
    r.makespan   = makespan_mirror;
    r.total_wait = wait_mirror;
    r.batch_done = last;
    if (last)
      clear_batch_mirror();
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Hold the job word until the block takes it, then record what it must return
  task automatic send_job(input logic [llj_pkg::DUR_W-1:0] dur, input logic last,
                          input logic typed, input dispatch_t typed_want);
    int unsigned gap;
    dispatch_t   predicted;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_duration <= dur;
    in_last_job <= last;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted = dispatch_job(dur, last);
    pending_dispatches.push_back(typed ? typed_want : predicted);
  endtask

  // Drop valid and hold off until every outstanding result word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dispatches.size() != 0) @(posedge clk);
  endtask

  task automatic set_active(input logic [llj_pkg::CFG_W-1:0] val);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    active_mirror = val;
  endtask

  // Result side: random stalls, compare each word taken with the oldest prediction
  initial begin : result_sink
    int unsigned stall;
    dispatch_t   want;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (pending_dispatches.size() == 0) begin
        $error("result word arrived with no job outstanding");
        mismatches++;
      end else begin
        want = pending_dispatches.pop_front();
        compare_field("counter_index", 64'(want.counter_index), 64'(out_counter_index));
        compare_field("start_time", 64'(want.start_time), 64'(out_start_time));
        compare_field("makespan", 64'(want.makespan), 64'(out_makespan));
        compare_field("total_wait", 64'(want.total_wait), 64'(out_total_wait));
        compare_field("batch_done", 64'(want.batch_done), 64'(out_batch_done));
      end
    end
  end

  initial begin : job_source
    int unsigned               random_jobs;
    int unsigned               phase_len;
    int unsigned               last_odds;
    int unsigned               k;
    logic [llj_pkg::CFG_W-1:0] cfg_pick;
    logic [llj_pkg::DUR_W-1:0] dur;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_duration <= '0;
    in_last_job <= 1'b0;
    clear_batch_mirror();
    active_mirror = 5'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed jobs
    foreach (job_table[r]) begin
      if (job_table[r].wr_cfg)
        set_active(job_table[r].cfg);
      send_job(job_table[r].dur, job_table[r].last, job_table[r].typed, job_table[r].want);
    end

    // random phases: a counter setting, then batches of random length that may run on
    random_jobs = 0;
    while (random_jobs < RANDOM_JOBS) begin
      case ($urandom_range(0, 7))
        0: cfg_pick = 5'd0;
        1: cfg_pick = 5'd1;
        2: cfg_pick = 5'd16;
        3: cfg_pick = 5'd17;
        4: cfg_pick = 5'd31;
        default: cfg_pick = llj_pkg::CFG_W'($urandom_range(0, 31));
      endcase
      set_active(cfg_pick);
      burst_mode = ($urandom_range(0, 3) == 0);
      last_odds  = $urandom_range(1, 40);
      phase_len  = $urandom_range(20, 120);
      for (k = 0; k < phase_len; k++) begin
        case ($urandom_range(0, 7))
          0: dur = '0;
          1: dur = '1;
          2, 3: dur = llj_pkg::DUR_W'($urandom_range(0, 15));
          default: dur = llj_pkg::DUR_W'($urandom_range(0, 16'hFFFF));
        endcase
        send_job(dur, $urandom_range(1, last_odds) == 1, 1'b0, NO_WANT);
        random_jobs++;
      end
    end

    // close on one counter; state must be clear again after the closing job
    set_active(5'd1);
    burst_mode = 1'b0;
    send_job(16'h0007, 1'b0, 1'b0, NO_WANT);
    send_job(16'h0009, 1'b1, 1'b0, NO_WANT);

    wait_drained();
    repeat (MAX_CNT + 4) @(posedge clk);
    if (mismatches == 0 && pending_dispatches.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== least_loaded_job_dispatch.f =====
rtl/core/llj_pkg.sv
rtl/core/llj_cell.sv
rtl/core/least_loaded_job_dispatch.sv
dv/least_loaded_job_dispatch_test.sv
